/* hdl/sbar_pkg.sv */
// Package for the stiff bar finite-difference step: request and response
// payload types, register indexes, fixed-point constants and bank helpers.
// No dependencies.
`default_nettype none
package sbar_pkg;

   typedef struct packed {
      logic               mode;
      logic [5:0]         point;
      logic signed [31:0] load_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               bad_point;
   } rsp_type;

   localparam int FRAC_BITS  = 28;
   localparam int COEF_BITS  = 33;
   localparam int CSR_BITS   = 29;
   localparam int POINT_BITS = 6;
   localparam int MIN_LAST   = 6;
   localparam int SWEEP_TAIL = 2;

   localparam logic [2:0] CSR_MU_SQUARED  = 3'd0;
   localparam logic [2:0] CSR_LOSS_FLAT   = 3'd1;
   localparam logic [2:0] CSR_LOSS_FREQ   = 3'd2;
   localparam logic [2:0] CSR_GRID_LAST   = 3'd3;
   localparam logic [2:0] CSR_CANCEL_LOW  = 3'd4;
   localparam logic [2:0] CSR_CANCEL_HIGH = 3'd5;

   localparam logic [5:0] GRID_LAST_RST   = 6'd63;
   localparam logic [5:0] CANCEL_LOW_RST  = 6'd12;
   localparam logic [5:0] CANCEL_HIGH_RST = 6'd50;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // Banks rotate modulo three.
   function automatic logic [1:0] bank_next(input logic [1:0] b);
      logic [1:0] r;
      r = (b == 2'd2) ? 2'd0 : b + 2'd1;
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/sbar_ram.sv */
// Generic synchronous RAM with one write port and two registered read ports.
// No dependencies.
`default_nettype none
module sbar_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   output      logic [WIDTH-1:0]         rdata_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output      logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;
endmodule
`default_nettype wire

/* hdl/sbar_stencil.sv */
// Stencil pipeline: sample windows, coefficient select, eight parallel
// products and a registered adder tree with floor shift and saturation.
// Depends on sbar_pkg.
`default_nettype none
module sbar_stencil import sbar_pkg::*; #(
   parameter int MAX_POINTS  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [CSR_BITS-1:0]             mu_squared,
   input  wire logic [CSR_BITS-1:0]             loss_flat,
   input  wire logic [CSR_BITS-1:0]             loss_freq,
   input  wire logic [$clog2(MAX_POINTS)-1:0]   n_eff,
   input  wire logic [POINT_BITS-1:0]           cancel_low,
   input  wire logic [POINT_BITS-1:0]           cancel_high,
   input  wire logic                            rd_vld,
   input  wire logic [$clog2(MAX_POINTS):0]     rd_idx,
   input  wire logic [SAMPLE_BITS-1:0]          u_data,
   input  wire logic [SAMPLE_BITS-1:0]          p_data,
   output      logic                            wr_en,
   output      logic [$clog2(MAX_POINTS)-1:0]   wr_idx,
   output      logic [SAMPLE_BITS-1:0]          wr_data,
   output      logic                            busy
);
   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = IW + 1;
   localparam int EW = IW + POINT_BITS + 1;
   localparam int PW = COEF_BITS + SAMPLE_BITS;
   localparam int SW = PW + 3;

   logic signed [SAMPLE_BITS-1:0] win_ff [5];
   logic signed [SAMPLE_BITS-1:0] pwin_ff [4];
   logic                          s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic [IW-1:0]                 s1_ctr_ff, s2_ctr_ff, s3_ctr_ff, s4_ctr_ff, s5_ctr_ff;
   logic signed [COEF_BITS-1:0]   coef [8];
   logic signed [SAMPLE_BITS-1:0] tap [8];
   logic signed [PW-1:0]          prod_ff [8];
   logic signed [SW-1:0]          sum4_ff [4];
   logic signed [SW-1:0]          sum2_ff [2];
   logic signed [SW-1:0]          sum1_ff;
   logic signed [COEF_BITS-1:0]   m_s, c1_s, c2_s, one_s;
   logic signed [COEF_BITS-1:0]   a6_ff, a5_ff, cb_ff, cc_ff;
   logic signed [SW-1:0]          shifted;
   logic [SW-SAMPLE_BITS:0]       top_bits;
   logic                          fits, cancel_hit;
   logic [CW-1:0]                 tail;

   assign tail = CW'(SWEEP_TAIL);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 5; k++) begin
            win_ff[k] <= '0;
         end
         for (int k = 0; k < 4; k++) begin
            pwin_ff[k] <= '0;
         end
      end else if (rd_vld) begin
         win_ff[0]  <= win_ff[1];
         win_ff[1]  <= win_ff[2];
         win_ff[2]  <= win_ff[3];
         win_ff[3]  <= win_ff[4];
         win_ff[4]  <= signed'(u_data);
         pwin_ff[0] <= pwin_ff[1];
         pwin_ff[1] <= pwin_ff[2];
         pwin_ff[2] <= pwin_ff[3];
         pwin_ff[3] <= signed'(p_data);
      end
      s1_ctr_ff <= IW'(rd_idx - tail);
      s2_ctr_ff <= s1_ctr_ff;
      s3_ctr_ff <= s2_ctr_ff;
      s4_ctr_ff <= s3_ctr_ff;
      s5_ctr_ff <= s4_ctr_ff;
      a6_ff <= (one_s <<< 1) - (m_s <<< 2) - (m_s <<< 1) - c1_s - (c2_s <<< 1);
      a5_ff <= (one_s <<< 1) - (m_s <<< 2) - m_s - c1_s - (c2_s <<< 1);
      cb_ff <= c1_s + (c2_s <<< 1) - one_s;
      cc_ff <= (m_s <<< 2) + c2_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= rd_vld && (rd_idx >= tail);
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_comb begin
      m_s   = signed'(COEF_BITS'(mu_squared));
      c1_s  = signed'(COEF_BITS'(loss_flat));
      c2_s  = signed'(COEF_BITS'(loss_freq));
      one_s = signed'(COEF_BITS'(1) << FRAC_BITS);
      tap[0] = win_ff[0];
      tap[1] = win_ff[1];
      tap[2] = win_ff[2];
      tap[3] = win_ff[3];
      tap[4] = win_ff[4];
      tap[5] = pwin_ff[0];
      tap[6] = pwin_ff[1];
      tap[7] = pwin_ff[2];
      coef[0] = -m_s;
      coef[1] = cc_ff;
      coef[2] = a6_ff;
      coef[3] = cc_ff;
      coef[4] = -m_s;
      coef[5] = -c2_s;
      coef[6] = cb_ff;
      coef[7] = -c2_s;
      if (s1_ctr_ff == '0) begin
         coef[0] = '0;
         coef[1] = '0;
         coef[3] = m_s <<< 2;
         coef[4] = -(m_s <<< 1);
         coef[5] = '0;
         coef[7] = '0;
      end else if (s1_ctr_ff == n_eff) begin
         coef[0] = -(m_s <<< 1);
         coef[1] = m_s <<< 2;
         coef[3] = '0;
         coef[4] = '0;
         coef[5] = '0;
         coef[7] = '0;
      end else if (s1_ctr_ff == IW'(1)) begin
         coef[0] = '0;
         coef[2] = a5_ff;
      end else if (s1_ctr_ff == n_eff - IW'(1)) begin
         coef[4] = '0;
         coef[2] = a5_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 8; k++) begin
         prod_ff[k] <= PW'(coef[k]) * PW'(tap[k]);
      end
      for (int k = 0; k < 4; k++) begin
         sum4_ff[k] <= SW'(prod_ff[2*k]) + SW'(prod_ff[2*k+1]);
      end
      sum2_ff[0] <= sum4_ff[0] + sum4_ff[1];
      sum2_ff[1] <= sum4_ff[2] + sum4_ff[3];
      sum1_ff    <= sum2_ff[0] + sum2_ff[1];
   end

   always_comb begin
      shifted    = sum1_ff >>> FRAC_BITS;
      top_bits   = shifted[SW-1:SAMPLE_BITS-1];
      fits       = (&top_bits) | ~(|top_bits);
      cancel_hit = (EW'(s5_ctr_ff) == EW'(cancel_low)) ||
                   (EW'(s5_ctr_ff) == EW'(cancel_high));
      if (cancel_hit) begin
         wr_data = '0;
      end else if (fits) begin
         wr_data = shifted[SAMPLE_BITS-1:0];
      end else begin
         wr_data = {shifted[SW-1], {(SAMPLE_BITS-1){~shifted[SW-1]}}};
      end
   end

   assign wr_en  = s5_vld_ff;
   assign wr_idx = s5_ctr_ff;
   assign busy   = s1_vld_ff | s2_vld_ff | s3_vld_ff | s4_vld_ff | s5_vld_ff;
endmodule
`default_nettype wire

/* hdl/stiff_bar_fdtd_step.sv */
// Top level of the damped stiff bar finite-difference step: control, config
// registers, bank rotation and the grid memory. Depends on sbar_pkg,
// sbar_ram and sbar_stencil.
//
//   Port group  Direction  Handshake            Payload
//   req_*       in         req_valid/req_ready  req_type
//   rsp_*       out        rsp_valid/rsp_ready  rsp_type
//   csr_*       in         csr_wr_en            csr_index, csr_wdata
//
// A load writes the value into the current and the previous bank, then
// responds. A tick sweeps N+3 memory reads, one grid point per cycle, then
// drains the stencil pipeline, rotates the banks and reads the result back.
// After reset a clearing pass writes zero to all 4*MAX_POINTS memory words
// while no request is accepted.
// One request is worked on at a time; a waiting response does not stop the
// next request from being accepted.
`default_nettype none
module stiff_bar_fdtd_step import sbar_pkg::*; #(
   parameter int MAX_POINTS  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire req_type             req_data,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      rsp_type             rsp_data,
   input  wire logic                csr_wr_en,
   input  wire logic [2:0]          csr_index,
   input  wire logic [CSR_BITS-1:0] csr_wdata
);
   localparam int IW    = $clog2(MAX_POINTS);
   localparam int CW    = IW + 1;
   localparam int AW    = IW + 2;
   localparam int EW    = IW + POINT_BITS + 1;
   localparam int XW    = (SAMPLE_BITS > 32) ? SAMPLE_BITS : 32;
   localparam int DEPTH = 1 << AW;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_CAPT  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [CSR_BITS-1:0]    mu_ff, flat_ff, freq_ff;
   logic [POINT_BITS-1:0]  last_ff, clow_ff, chigh_ff;
   logic [1:0]             rot_ff, rot_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [CW-1:0]          issue_ff, issue_in;
   logic                   rd_vld_ff;
   logic [CW-1:0]          rd_idx_ff;
   logic [POINT_BITS-1:0]  pt_ff, pt_in;
   logic [SAMPLE_BITS-1:0] lv_ff, lv_in;
   logic signed [31:0]     res_ff, res_in;
   logic                   bad_ff, bad_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [EW-1:0]          gl_ext, n_ext;
   logic [IW-1:0]          n_eff;
   logic                   accept, req_bad;
   logic [1:0]             bank_after, bank_before;
   logic signed [XW-1:0]   lv_x, rd_x;
   logic [XW-SAMPLE_BITS:0] lv_top;
   logic [XW-32:0]         rd_top;
   logic [SAMPLE_BITS-1:0] lv_sat;
   logic signed [31:0]     lv_out, rd_out;
   logic                   we;
   logic [AW-1:0]          waddr, raddr_a, raddr_b;
   logic [SAMPLE_BITS-1:0] wdata, rdata_a, rdata_b;
   logic                   st_wr_en, st_busy;
   logic [IW-1:0]          st_wr_idx;
   logic [SAMPLE_BITS-1:0] st_wr_data;
   logic                   out_free;

   always_comb begin
      gl_ext = EW'(last_ff);
      if (gl_ext < EW'(MIN_LAST)) begin
         n_ext = EW'(MIN_LAST);
      end else if (gl_ext > EW'(MAX_POINTS - 1)) begin
         n_ext = EW'(MAX_POINTS - 1);
      end else begin
         n_ext = gl_ext;
      end
      n_eff   = n_ext[IW-1:0];
      req_bad = EW'(req_data.point) > n_ext;
   end

   assign bank_after  = bank_next(rot_ff);
   assign bank_before = bank_next(bank_after);

   always_comb begin
      lv_x   = XW'(req_data.load_value);
      lv_top = lv_x[XW-1:SAMPLE_BITS-1];
      if ((&lv_top) | ~(|lv_top)) begin
         lv_sat = lv_x[SAMPLE_BITS-1:0];
      end else begin
         lv_sat = {lv_x[XW-1], {(SAMPLE_BITS-1){~lv_x[XW-1]}}};
      end
      lv_out = 32'(signed'(lv_sat));
      rd_x   = XW'(signed'(rdata_a));
      rd_top = rd_x[XW-1:31];
      if ((&rd_top) | ~(|rd_top)) begin
         rd_out = rd_x[31:0];
      end else begin
         rd_out = {rd_x[XW-1], {31{~rd_x[XW-1]}}};
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rot_in       = rot_ff;
      clr_in       = clr_ff;
      issue_in     = issue_ff;
      pt_in        = pt_ff;
      lv_in        = lv_ff;
      res_in       = res_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      we           = 1'b0;
      waddr        = '0;
      wdata        = '0;
      raddr_a      = {rot_ff, issue_ff[IW-1:0]};
      raddr_b      = {bank_before, issue_ff[IW-1:0]};
      unique case (state_ff)
         ST_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               pt_in    = req_data.point;
               lv_in    = lv_sat;
               bad_in   = req_bad;
               issue_in = '0;
               if (req_data.mode == MODE_LOAD) begin
                  res_in   = req_bad ? '0 : lv_out;
                  we       = !req_bad;
                  waddr    = {rot_ff, IW'(req_data.point)};
                  wdata    = lv_sat;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_LOAD: begin
            we       = !bad_ff;
            waddr    = {bank_before, IW'(pt_ff)};
            wdata    = lv_ff;
            state_in = ST_DONE;
         end
         ST_SWEEP: begin
            issue_in = issue_ff + CW'(1);
            if (issue_ff == CW'(n_eff) + CW'(SWEEP_TAIL)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !st_busy) begin
               rot_in   = bank_after;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            raddr_a  = {rot_ff, IW'(pt_ff)};
            state_in = ST_CAPT;
         end
         ST_CAPT: begin
            res_in   = bad_ff ? '0 : rd_out;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.sample    = res_ff;
               rsp_data_in.bad_point = bad_ff;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (st_wr_en) begin
         we    = 1'b1;
         waddr = {bank_after, st_wr_idx};
         wdata = st_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rot_ff       <= '0;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mu_ff        <= '0;
         flat_ff      <= '0;
         freq_ff      <= '0;
         last_ff      <= GRID_LAST_RST;
         clow_ff      <= CANCEL_LOW_RST;
         chigh_ff     <= CANCEL_HIGH_RST;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         clr_ff       <= clr_in;
         rd_vld_ff    <= (state_ff == ST_SWEEP);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MU_SQUARED:  mu_ff    <= csr_wdata;
               CSR_LOSS_FLAT:   flat_ff  <= csr_wdata;
               CSR_LOSS_FREQ:   freq_ff  <= csr_wdata;
               CSR_GRID_LAST:   last_ff  <= csr_wdata[POINT_BITS-1:0];
               CSR_CANCEL_LOW:  clow_ff  <= csr_wdata[POINT_BITS-1:0];
               CSR_CANCEL_HIGH: chigh_ff <= csr_wdata[POINT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      rd_idx_ff   <= issue_ff;
      pt_ff       <= pt_in;
      lv_ff       <= lv_in;
      res_ff      <= res_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
   end

   sbar_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .rdata_a (rdata_a),
      .raddr_b (raddr_b),
      .rdata_b (rdata_b)
   );

   sbar_stencil #(
      .MAX_POINTS  (MAX_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_stencil (
      .clock       (clock),
      .reset       (reset),
      .mu_squared  (mu_ff),
      .loss_flat   (flat_ff),
      .loss_freq   (freq_ff),
      .n_eff       (n_eff),
      .cancel_low  (clow_ff),
      .cancel_high (chigh_ff),
      .rd_vld      (rd_vld_ff),
      .rd_idx      (rd_idx_ff),
      .u_data      (rdata_a),
      .p_data      (rdata_b),
      .wr_en       (st_wr_en),
      .wr_idx      (st_wr_idx),
      .wr_data     (st_wr_data),
      .busy        (st_busy)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire
